// ===== sv/spq_pkg.sv =====
// Shared types and codes for the sorted priority ready queue.
package spq_pkg;

	localparam logic MODE_ENQ = 1'b0;
	localparam logic MODE_DEQ = 1'b1;

	localparam logic [1:0] STAT_ENQUEUED = 2'd0;
	localparam logic [1:0] STAT_DEQUEUED = 2'd1;
	localparam logic [1:0] STAT_EMPTY    = 2'd2;
	localparam logic [1:0] STAT_FULL     = 2'd3;

	typedef struct packed {
		logic       mode;
		logic [7:0] proc_id;
		logic [7:0] prio;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] out_id;
		logic [7:0] out_prio;
		logic [4:0] occupancy;
	} rsp_t;

	typedef struct packed {
		logic [7:0] proc_id;
		logic [7:0] prio;
	} entry_t;

endpackage

// ===== sv/sorted_priority_ready_queue_top.sv =====
// Sorted priority ready queue: circular entry memory with insertion-sort enqueue.
//
// Request channel (req_valid/req_ready, payload req): mode 0 inserts proc_id/prio
// behind every held entry of equal or higher priority; mode 1 removes the head.
// Response channel (rsp_valid/rsp_ready, payload rsp): exactly one transaction per
// request, with status, the removed entry on a dequeue, and the occupancy after it.
//
// One request is processed at a time; req_ready is high while the block is idle.
// Paths from request to response: a rejected enqueue (full), an enqueue into an empty
// queue and a dequeue of an empty queue go straight from idle to the output state; a
// dequeue does one read of the head entry and the head pointer advances; any other
// enqueue moves m entries back one place, then writes the new entry in place.
// An enqueue walks from the tail toward the head, one entry per cycle: each
// cycle compares the entry read in the previous cycle, writes it one place
// further back, and reads the next one. The single-port-pair entry memory
// sets this pace.
// Reset empties the queue at once (count and head cleared); entry contents
// are not cleared. A stalled response is held in the output register; the
// next request is accepted meanwhile and waits finished until it is taken.
module sorted_priority_ready_queue_top #(
	parameter int CAPACITY = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  spq_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output spq_pkg::rsp_t  rsp
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_INS  = 5'b00100,
		S_DEQ  = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [AW-1:0]   head_q;
	logic [CW-1:0]   k_q;
	logic            rsp_valid_q;
	spq_pkg::entry_t new_q;
	logic [1:0]      res_status_q;
	spq_pkg::entry_t res_entry_q;
	spq_pkg::rsp_t   rsp_q;

	spq_pkg::entry_t mem [CAPACITY];
	spq_pkg::entry_t rdata_q;

	logic            acc;
	logic            full;
	logic            empty;
	logic            rd_lt;
	logic            mem_we;
	logic [AW-1:0]   mem_wa;
	spq_pkg::entry_t mem_wd;
	logic [AW-1:0]   mem_ra;
	logic            out_load;

	// logical position k from the head to a physical slot
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] k);
		logic [CW:0] s;
		s = (CW+1)'(h) + (CW+1)'(k);
		if (s >= (CW+1)'(CAPACITY))
			s = s - (CW+1)'(CAPACITY);
		return s[AW-1:0];
	endfunction

	assign req_ready = (state_q == S_IDLE);
	assign acc       = req_valid && req_ready;
	assign full      = (count_q == CW'(CAPACITY));
	assign empty     = (count_q == '0);
	assign rd_lt     = (rdata_q.prio < new_q.prio);
	assign out_load  = (state_q == S_OUT) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = head_q;
		mem_wd = new_q;
		mem_ra = head_q;
		unique case (state_q)
			S_IDLE: begin
				if (req.mode == spq_pkg::MODE_ENQ)
					mem_ra = phys(head_q, count_q - CW'(1));
				if (acc && req.mode == spq_pkg::MODE_ENQ && !full && empty) begin
					mem_we = 1'b1;
					mem_wa = head_q;
					mem_wd = '{proc_id: req.proc_id, prio: req.prio};
				end
			end
			S_SCAN: begin
				// read ahead of the write; k-2 wraps only when it goes unused
				mem_ra = phys(head_q, k_q - CW'(2));
				mem_we = 1'b1;
				mem_wa = phys(head_q, k_q);
				mem_wd = rd_lt ? rdata_q : new_q;
			end
			S_INS: begin
				mem_we = 1'b1;
				mem_wa = phys(head_q, k_q);
				mem_wd = new_q;
			end
			S_DEQ, S_OUT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rdata_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			head_q      <= '0;
			k_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (out_load)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (req.mode == spq_pkg::MODE_ENQ) begin
							if (full) begin
								state_q <= S_OUT;
							end else if (empty) begin
								count_q <= count_q + CW'(1);
								state_q <= S_OUT;
							end else begin
								k_q     <= count_q;
								state_q <= S_SCAN;
							end
						end else begin
							state_q <= empty ? S_OUT : S_DEQ;
						end
					end
				end
				S_SCAN: begin
					if (rd_lt) begin
						k_q <= k_q - CW'(1);
						if (k_q == CW'(1))
							state_q <= S_INS;
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= S_OUT;
					end
				end
				S_INS: begin
					count_q <= count_q + CW'(1);
					state_q <= S_OUT;
				end
				S_DEQ: begin
					head_q  <= (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + AW'(1);
					count_q <= count_q - CW'(1);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			new_q       <= '{proc_id: req.proc_id, prio: req.prio};
			res_entry_q <= '0;
			if (req.mode == spq_pkg::MODE_ENQ)
				res_status_q <= full ? spq_pkg::STAT_FULL : spq_pkg::STAT_ENQUEUED;
			else
				res_status_q <= empty ? spq_pkg::STAT_EMPTY : spq_pkg::STAT_DEQUEUED;
		end
		if (state_q == S_DEQ)
			res_entry_q <= rdata_q;
		if (out_load) begin
			rsp_q.status    <= res_status_q;
			rsp_q.out_id    <= res_entry_q.proc_id;
			rsp_q.out_prio  <= res_entry_q.prio;
			rsp_q.occupancy <= 5'(count_q);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("queue count above capacity");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= AW'(CAPACITY - 1))
		else $error("head pointer out of range");

	a_scan_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> (k_q != '0) && (k_q <= count_q) && !full)
		else $error("insert scan position out of range");

	a_full_reject: assert property (@(posedge clk) disable iff (!arst_n)
		acc && req.mode == spq_pkg::MODE_ENQ && full |=> state_q == S_OUT && full)
		else $error("enqueue into full queue changed state");

	a_deq_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DEQ |=> count_q == $past(count_q) - CW'(1))
		else $error("dequeue did not shrink queue");

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for the sorted priority ready queue: scoreboard-checked directed and random traffic.
`timescale 1ns / 100ps

module tb_top;

	localparam int DEPTH        = 16;
	localparam int RANDOM_ITEMS = 530;
	localparam int QUIET_TAIL   = 60;
	localparam int DRAIN_CYCLES = DEPTH + 8;
	localparam int CYCLE_LIMIT  = 200000;

	// Keeps a sorted copy of the held entries and the responses they imply.
	class ready_queue_scoreboard;
		spq_pkg::entry_t held[$];
		spq_pkg::rsp_t   pending_rsp[$];
		int              errors = 0;

		function void note_request(spq_pkg::req_t r);
			spq_pkg::rsp_t   want;
			spq_pkg::entry_t ent;
			int              pos;
			want = '0;
			if (r.mode == spq_pkg::MODE_ENQ) begin
				if (held.size() >= DEPTH) begin
					want.status = spq_pkg::STAT_FULL;
				end else begin
					// insert behind every entry of equal or higher priority
					pos = 0;
					while (pos < held.size() && held[pos].prio >= r.prio)
						pos++;
					ent.proc_id = r.proc_id;
					ent.prio    = r.prio;
					held.insert(pos, ent);
					want.status = spq_pkg::STAT_ENQUEUED;
				end
			end else if (held.size() == 0) begin
				want.status = spq_pkg::STAT_EMPTY;
			end else begin
				ent           = held.pop_front();
				want.status   = spq_pkg::STAT_DEQUEUED;
				want.out_id   = ent.proc_id;
				want.out_prio = ent.prio;
			end
			want.occupancy = 5'(held.size());
			pending_rsp.push_back(want);
		endfunction

		function void check_response(spq_pkg::rsp_t got);
			spq_pkg::rsp_t want;
			if (pending_rsp.size() == 0) begin
				$error("response transaction with none outstanding: %h", got);
				errors++;
				return;
			end
			want = pending_rsp.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				errors++;
			end
			if (got.out_id !== want.out_id) begin
				$error("out_id: expected %0d, actual %0d", want.out_id, got.out_id);
				errors++;
			end
			if (got.out_prio !== want.out_prio) begin
				$error("out_prio: expected %0d, actual %0d", want.out_prio, got.out_prio);
				errors++;
			end
			if (got.occupancy !== want.occupancy) begin
				$error("occupancy: expected %0d, actual %0d", want.occupancy, got.occupancy);
				errors++;
			end
		endfunction
	endclass

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_ready;
	spq_pkg::req_t  req       = '0;
	logic           rsp_valid;
	logic           rsp_ready = 1'b0;
	spq_pkg::rsp_t  rsp;

	bit    idle_on    = 1'b0;
	int    stall_left = 0;
	int    cycles     = 0;

	ready_queue_scoreboard sb = new;

	sorted_priority_ready_queue_top #(.CAPACITY(DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// response side back-pressure, in random bursts while idle_on is set
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			rsp_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 4);
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid === 1'b1 && rsp_ready)
			sb.check_response(rsp);
	end

	function automatic spq_pkg::req_t make_req(logic mode, logic [7:0] proc_id,
			logic [7:0] prio);
		spq_pkg::req_t r;
		r.mode    = mode;
		r.proc_id = proc_id;
		r.prio    = prio;
		return r;
	endfunction

	// Present one request transaction; returns right after the accepting edge.
	task automatic send_request(spq_pkg::req_t r);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do
			@(posedge clk);
		while (!req_ready);
		sb.note_request(r);
	endtask

	initial begin
		int            sent;
		int            phase_len;
		int            enq_pct;
		bit            phase_idle;
		spq_pkg::req_t r;

		sent = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		idle_on = 1'b1;

		// directed: empty dequeue, extremes, ties, fill to capacity, rejected enqueue, dequeues
		send_request(make_req(spq_pkg::MODE_DEQ, 8'h5A, 8'hA5));
		send_request(make_req(spq_pkg::MODE_ENQ, 8'h00, 8'h00));
		send_request(make_req(spq_pkg::MODE_ENQ, 8'hFF, 8'hFF));
		send_request(make_req(spq_pkg::MODE_ENQ, 8'h01, 8'h80));
		send_request(make_req(spq_pkg::MODE_ENQ, 8'h02, 8'h80));
		send_request(make_req(spq_pkg::MODE_ENQ, 8'h03, 8'h80));
		send_request(make_req(spq_pkg::MODE_ENQ, 8'hAA, 8'h55));
		send_request(make_req(spq_pkg::MODE_ENQ, 8'h55, 8'hAA));
		send_request(make_req(spq_pkg::MODE_ENQ, 8'h10, 8'hFF));
		send_request(make_req(spq_pkg::MODE_ENQ, 8'h11, 8'h00));
		for (int k = 0; k < DEPTH - 9; k++)
			send_request(make_req(spq_pkg::MODE_ENQ, 8'(8'h20 + k), 8'(k * 37)));
		send_request(make_req(spq_pkg::MODE_ENQ, 8'hEE, 8'hFF));
		send_request(make_req(spq_pkg::MODE_DEQ, 8'hFF, 8'hFF));
		send_request(make_req(spq_pkg::MODE_DEQ, 8'h00, 8'h00));
		send_request(make_req(spq_pkg::MODE_DEQ, 8'hC3, 8'h3C));

		// random phases biased toward filling, draining, or mixed traffic
		while (sent < RANDOM_ITEMS) begin
			phase_len = $urandom_range(10, 40);
			case ($urandom_range(0, 2))
				0: enq_pct = 85;
				1: enq_pct = 15;
				default: enq_pct = 50;
			endcase
			phase_idle = ($urandom_range(0, 3) != 0);
			repeat (phase_len) begin
				if (sent >= RANDOM_ITEMS)
					break;
				idle_on   = phase_idle && (sent < RANDOM_ITEMS - QUIET_TAIL);
				r.mode    = ($urandom_range(0, 99) < enq_pct) ? spq_pkg::MODE_ENQ
					: spq_pkg::MODE_DEQ;
				r.proc_id = 8'($urandom_range(0, 255));
				// narrow ranges make priority ties common
				case ($urandom_range(0, 2))
					0: r.prio = 8'($urandom_range(0, 255));
					1: r.prio = 8'($urandom_range(0, 3));
					default: r.prio = 8'($urandom_range(252, 255));
				endcase
				send_request(r);
				sent++;
			end
		end
		idle_on = 1'b0;

		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
sv/spq_pkg.sv
sv/sorted_priority_ready_queue_top.sv
tb/sv/tb_top.sv
